>>> hdl/hrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_pkg
// Types and constants shared by the heartbeat rate monitor modules.
// ----------------------------------------------------------------------------
package hrm_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOG_DEPTH = 4'd1;

	localparam logic [6:0] WINDOW_LENGTH_RST = 7'd16;
	localparam logic [10:0] LOG_DEPTH_RST = 11'd1024;

	// field widths
	localparam int TS_W = 63;
	localparam int TAG_W = 32;
	localparam int SLOT_OUT_W = 10;
	localparam int RATE_W = 48;
	localparam int OPND_W = 64;

	// 1e9 * 2^16, split into 32-bit and 14-bit halves for the multiplier
	localparam logic [45:0] NS_Q16 = 46'd65536000000000;
	localparam logic [31:0] NS_Q16_LO = NS_Q16[31:0];
	localparam logic [31:0] NS_Q16_HI = {18'd0, NS_Q16[45:32]};

	// dividend of 64 x 46 bits, worked two bits a step
	localparam int DVD_W = 110;
	localparam int DIV_STEPS = DVD_W / 2;
	localparam int MUL_PARTS = 4;

	typedef enum logic [1:0] {
		DIV_INST,
		DIV_WAVG,
		DIV_GLB
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WIN,
		ST_INST,
		ST_INST_W,
		ST_WAVG,
		ST_WAVG_W,
		ST_GLB,
		ST_GLB_W,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic win_upd;
		logic div_start;
		div_sel_t div_sel;
		logic store_res;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic started;
		logic div_done;
	} dp_sts_t;

endpackage

>>> hdl/hrm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_div
// Scaled divider: floor(a * 1e9 * 2^16 / d), clamped to 48 bits. Four 32x32
// partial products build the dividend, then two quotient bits per cycle.
// ----------------------------------------------------------------------------
module hrm_div import hrm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [OPND_W-1:0] a,
	input  logic [OPND_W-1:0] d,
	output logic              done,
	output logic [RATE_W-1:0] q
);

	logic [OPND_W-1:0] a_q, d_q, rem_q;
	logic [63:0] pp_q;
	logic [6:0] sh_q;
	logic [DVD_W-1:0] acc_q;
	logic [2:0] mul_cnt_q;
	logic [5:0] step_q;
	logic mul_q, div_q, done_q, over_q;
	logic [RATE_W-1:0] quo_q;

	logic [31:0] a_half, k_half;
	logic [OPND_W:0] r1, r2, r1_sub, r2_sub;
	logic [OPND_W-1:0] rem1, rem2;
	logic qb1, qb0;

	// partial product operand select
	always_comb begin
		a_half = mul_cnt_q[1] ? a_q[63:32] : a_q[31:0];
		k_half = mul_cnt_q[0] ? NS_Q16_HI : NS_Q16_LO;
	end

	// two restoring steps
	always_comb begin
		r1 = {rem_q, acc_q[DVD_W-1]};
		r1_sub = r1 - {1'b0, d_q};
		qb1 = (r1 >= {1'b0, d_q});
		rem1 = qb1 ? r1_sub[OPND_W-1:0] : r1[OPND_W-1:0];
		r2 = {rem1, acc_q[DVD_W-2]};
		r2_sub = r2 - {1'b0, d_q};
		qb0 = (r2 >= {1'b0, d_q});
		rem2 = qb0 ? r2_sub[OPND_W-1:0] : r2[OPND_W-1:0];
	end

	// control of the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q <= 1'b0;
			div_q <= 1'b0;
			done_q <= 1'b0;
			mul_cnt_q <= '0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mul_q <= 1'b1;
				mul_cnt_q <= '0;
			end else if (mul_q) begin
				mul_cnt_q <= mul_cnt_q + 3'd1;
				if (mul_cnt_q == 3'(MUL_PARTS)) begin
					mul_q <= 1'b0;
					div_q <= 1'b1;
					step_q <= '0;
				end
			end else if (div_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'(DIV_STEPS - 1)) begin
					div_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath of the unit
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			d_q <= d;
			acc_q <= '0;
		end else if (mul_q) begin
			if (mul_cnt_q < 3'(MUL_PARTS)) begin
				pp_q <= 64'(a_half) * 64'(k_half);
				sh_q <= {1'b0, mul_cnt_q[1], 5'd0} + {1'b0, mul_cnt_q[0], 5'd0};
			end
			if (mul_cnt_q != 3'd0)
				acc_q <= acc_q + (DVD_W'(pp_q) << sh_q);
			rem_q <= '0;
			quo_q <= '0;
			over_q <= 1'b0;
		end else if (div_q) begin
			acc_q <= acc_q << 2;
			rem_q <= rem2;
			quo_q <= {quo_q[RATE_W-3:0], qb1, qb0};
			over_q <= over_q | quo_q[RATE_W-1] | quo_q[RATE_W-2];
		end
	end

	assign done = done_q;
	assign q = over_q ? {RATE_W{1'b1}} : quo_q;

endmodule

>>> hdl/hrm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_dp
// Datapath: configuration, beat state, interval window and result registers.
// ----------------------------------------------------------------------------
module hrm_dp import hrm_pkg::*; #(
	parameter int WINDOW_MAX = 64,
	parameter int LOG_SLOTS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [TS_W-1:0]       timestamp_ns,
	input  logic signed [TAG_W-1:0] beat_tag,
	output logic [TS_W-1:0]       beat_number,
	output logic signed [TAG_W-1:0] tag_out,
	output logic [TS_W-1:0]       time_out,
	output logic [SLOT_OUT_W-1:0] record_slot,
	output logic [SLOT_OUT_W-1:0] read_slot,
	output logic [RATE_W-1:0]     inst_bps,
	output logic [RATE_W-1:0]     wavg_bps,
	output logic [RATE_W-1:0]     glb_bps,
	output logic                  rate_saturated
);

	localparam int WIN_AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int SLOT_W = $clog2(LOG_SLOTS + 1);

	// configuration
	logic [6:0] window_length_q;
	logic [10:0] log_depth_q;

	// beat state
	logic started_q;
	logic [TS_W-1:0] first_time_q, last_time_q, beat_count_q;
	logic [OPND_W-1:0] window_sum_q;
	logic [WIN_AW-1:0] window_pos_q, wpos_q;
	logic window_full_q;
	logic [SLOT_W-1:0] write_slot_q, read_pos_q, rec_slot_q;

	// per-item working registers
	logic [TS_W-1:0] ts_q, beat_num_q, interval_q, elapsed_q;
	logic signed [TAG_W-1:0] tag_q;
	logic [OPND_W-1:0] beat_plus_q;
	logic [CNT_W-1:0] count_q;
	logic [RATE_W-1:0] inst_q, wavg_q, glb_q;
	logic sat_q;

	// window store
	logic [TS_W-1:0] win_mem [WINDOW_MAX];
	logic [TS_W-1:0] rd_q;

	// output register
	logic [TS_W-1:0] o_beat_q, o_time_q;
	logic signed [TAG_W-1:0] o_tag_q;
	logic [SLOT_OUT_W-1:0] o_rec_q, o_read_q;
	logic [RATE_W-1:0] o_inst_q, o_wavg_q, o_glb_q;
	logic o_sat_q;

	logic [CNT_W-1:0] win_eff, wpos_nxt;
	logic [SLOT_W-1:0] depth_eff, wslot, wnext, radj, rnext;
	logic [WIN_AW-1:0] wpos_adj;
	logic [OPND_W-1:0] div_a, div_d;
	logic div_done;
	logic [RATE_W-1:0] div_q;

	// effective register values
	always_comb begin
		if (window_length_q == 7'd0)
			win_eff = CNT_W'(1);
		else if (32'(window_length_q) > WINDOW_MAX)
			win_eff = CNT_W'(WINDOW_MAX);
		else
			win_eff = CNT_W'(window_length_q);
		if (log_depth_q == 11'd0)
			depth_eff = SLOT_W'(1);
		else if (32'(log_depth_q) > LOG_SLOTS)
			depth_eff = SLOT_W'(LOG_SLOTS);
		else
			depth_eff = SLOT_W'(log_depth_q);
	end

	// slot and window position wrap
	always_comb begin
		wslot = (write_slot_q >= depth_eff) ? '0 : write_slot_q;
		wnext = ((wslot + SLOT_W'(1)) >= depth_eff) ? '0 : wslot + SLOT_W'(1);
		radj = (read_pos_q >= depth_eff) ? '0 : read_pos_q;
		rnext = ((radj + SLOT_W'(1)) >= depth_eff) ? '0 : radj + SLOT_W'(1);
		wpos_adj = (CNT_W'(window_pos_q) >= win_eff) ? '0 : window_pos_q;
		wpos_nxt = CNT_W'(wpos_q) + CNT_W'(1);
	end

	// divider operand select
	always_comb begin
		case (cmd.div_sel)
			DIV_INST: begin
				div_a = OPND_W'(1);
				div_d = {1'b0, interval_q};
			end
			DIV_WAVG: begin
				div_a = OPND_W'(count_q);
				div_d = window_sum_q;
			end
			DIV_GLB: begin
				div_a = beat_plus_q;
				div_d = {1'b0, elapsed_q};
			end
			default: begin
				div_a = '0;
				div_d = '0;
			end
		endcase
	end

	hrm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.a     (div_a),
		.d     (div_d),
		.done  (div_done),
		.q     (div_q)
	);

	// configuration and beat state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_LENGTH_RST;
			log_depth_q <= LOG_DEPTH_RST;
			started_q <= 1'b0;
			first_time_q <= '0;
			last_time_q <= '0;
			beat_count_q <= '0;
			window_sum_q <= '0;
			window_pos_q <= '0;
			window_full_q <= 1'b0;
			write_slot_q <= '0;
			read_pos_q <= '0;
		end else begin
			if (cfg_wr_en && cfg_index == CFG_WINDOW_LENGTH) begin
				window_length_q <= cfg_data[6:0];
				window_pos_q <= '0;
				window_full_q <= 1'b0;
				window_sum_q <= '0;
			end
			if (cfg_wr_en && cfg_index == CFG_LOG_DEPTH)
				log_depth_q <= cfg_data;
			if (cmd.load) begin
				write_slot_q <= wnext;
				beat_count_q <= beat_count_q + TS_W'(1);
				last_time_q <= timestamp_ns;
				if (!started_q) begin
					started_q <= 1'b1;
					first_time_q <= timestamp_ns;
					read_pos_q <= radj;
				end else begin
					read_pos_q <= rnext;
				end
			end
			// window update: drop the oldest interval once full
			if (cmd.win_upd) begin
				window_sum_q <= window_sum_q - (window_full_q ? {1'b0, rd_q} : '0)
					+ {1'b0, interval_q};
				if (wpos_nxt >= win_eff) begin
					window_pos_q <= '0;
					window_full_q <= 1'b1;
				end else begin
					window_pos_q <= WIN_AW'(wpos_nxt);
				end
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ts_q <= timestamp_ns;
			tag_q <= beat_tag;
			rec_slot_q <= wslot;
			beat_num_q <= beat_count_q;
			beat_plus_q <= {1'b0, beat_count_q} + OPND_W'(1);
			interval_q <= timestamp_ns - last_time_q;
			elapsed_q <= timestamp_ns - first_time_q;
			wpos_q <= wpos_adj;
			inst_q <= '0;
			wavg_q <= '0;
			glb_q <= '0;
			sat_q <= 1'b0;
		end
		if (cmd.win_upd)
			count_q <= window_full_q ? win_eff : wpos_nxt;
		if (cmd.store_res) begin
			if (div_d == '0)
				sat_q <= 1'b1;
			case (cmd.div_sel)
				DIV_INST: inst_q <= div_q;
				DIV_WAVG: wavg_q <= div_q;
				DIV_GLB: glb_q <= div_q;
				default: ;
			endcase
		end
	end

	// interval store
	always_ff @(posedge clk) begin
		if (cmd.load)
			rd_q <= win_mem[wpos_adj];
		if (cmd.win_upd)
			win_mem[wpos_q] <= interval_q;
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_beat_q <= beat_num_q;
			o_tag_q <= tag_q;
			o_time_q <= ts_q;
			o_rec_q <= SLOT_OUT_W'(rec_slot_q);
			o_read_q <= SLOT_OUT_W'(read_pos_q);
			o_inst_q <= inst_q;
			o_wavg_q <= wavg_q;
			o_glb_q <= glb_q;
			o_sat_q <= sat_q;
		end
	end

	assign sts.started = started_q;
	assign sts.div_done = div_done;

	assign beat_number = o_beat_q;
	assign tag_out = o_tag_q;
	assign time_out = o_time_q;
	assign record_slot = o_rec_q;
	assign read_slot = o_read_q;
	assign inst_bps = o_inst_q;
	assign wavg_bps = o_wavg_q;
	assign glb_bps = o_glb_q;
	assign rate_saturated = o_sat_q;

endmodule

>>> hdl/hrm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_ctrl
// Controller: sequences window update, three divisions (not for beat 0), hand-off.
// ----------------------------------------------------------------------------
module hrm_ctrl import hrm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_nxt;
	logic out_valid_q;
	logic accept, out_free;

	assign accept = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_nxt = sts.started ? ST_WIN : ST_DONE;
			ST_WIN: state_nxt = ST_INST;
			ST_INST: state_nxt = ST_INST_W;
			ST_INST_W: if (sts.div_done) state_nxt = ST_WAVG;
			ST_WAVG: state_nxt = ST_WAVG_W;
			ST_WAVG_W: if (sts.div_done) state_nxt = ST_GLB;
			ST_GLB: state_nxt = ST_GLB_W;
			ST_GLB_W: if (sts.div_done) state_nxt = ST_DONE;
			ST_DONE: if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.div_sel = DIV_INST;
		case (state_q)
			ST_IDLE: cmd.load = accept;
			ST_WIN: cmd.win_upd = 1'b1;
			ST_INST: cmd.div_start = 1'b1;
			ST_INST_W: cmd.store_res = sts.div_done;
			ST_WAVG: begin
				cmd.div_sel = DIV_WAVG;
				cmd.div_start = 1'b1;
			end
			ST_WAVG_W: begin
				cmd.div_sel = DIV_WAVG;
				cmd.store_res = sts.div_done;
			end
			ST_GLB: begin
				cmd.div_sel = DIV_GLB;
				cmd.div_start = 1'b1;
			end
			ST_GLB_W: begin
				cmd.div_sel = DIV_GLB;
				cmd.store_res = sts.div_done;
			end
			ST_DONE: cmd.out_load = out_free;
			default: ;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> hdl/heartbeat_rate_monitor_unit.sv
`timescale 1ns / 1ps
// After acceptance, the first beat after reset goes straight to the output load;
// later beats pass a window update and three divisions (start, multiply, 55 divide
// steps, done), then the output load. A new beat is accepted only in the idle state,
// after the previous one has been passed to the output register;
// an undrained result in the output register holds the load until it leaves.
// Reset (arst_n low, asynchronous) clears beat state; window_length 16, log_depth 1024.
// ----------------------------------------------------------------------------
// heartbeat_rate_monitor_unit
// Heartbeat rate monitor: one record per beat with instant, window and global
// rates in Q32.16 beats per second.
// ----------------------------------------------------------------------------
module heartbeat_rate_monitor_unit import hrm_pkg::*; #(
	parameter int WINDOW_MAX = 64,
	parameter int LOG_SLOTS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TS_W-1:0]       timestamp_ns,
	input  logic signed [TAG_W-1:0] beat_tag,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [TS_W-1:0]       beat_number,
	output logic signed [TAG_W-1:0] tag_out,
	output logic [TS_W-1:0]       time_out,
	output logic [SLOT_OUT_W-1:0] record_slot,
	output logic [SLOT_OUT_W-1:0] read_slot,
	output logic [RATE_W-1:0]     inst_bps,
	output logic [RATE_W-1:0]     wavg_bps,
	output logic [RATE_W-1:0]     glb_bps,
	output logic                  rate_saturated
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	hrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hrm_dp #(
		.WINDOW_MAX(WINDOW_MAX),
		.LOG_SLOTS (LOG_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.timestamp_ns  (timestamp_ns),
		.beat_tag      (beat_tag),
		.beat_number   (beat_number),
		.tag_out       (tag_out),
		.time_out      (time_out),
		.record_slot   (record_slot),
		.read_slot     (read_slot),
		.inst_bps      (inst_bps),
		.wavg_bps      (wavg_bps),
		.glb_bps       (glb_bps),
		.rate_saturated(rate_saturated)
	);

endmodule
